>>> rtl/lavm_pkg.sv
package lavm_pkg;

    localparam int WORD_W         = 32;
    localparam int IN_W           = 9 * WORD_W;
    localparam int OUT_W          = 12 * WORD_W;
    // The largest normalized magnitude of a nonzero vector sits in [2^29, 2^30) before the length is taken.
    localparam int NORM_BITS      = 30;
    localparam int AXIS_FRAC_BITS = 30;

    typedef logic [2:0][WORD_W-1:0] t_vec3;

endpackage

>>> rtl/lavm_norm.sv
module lavm_norm #(
    parameter int CW             = 33,
    parameter int SBW            = 1,
    parameter int AXIS_FRAC_BITS = lavm_pkg::AXIS_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  logic [3*CW-1:0]       i_vec,
    input  logic [SBW-1:0]        i_sb,
    output logic                  o_valid,
    output lavm_pkg::t_vec3       o_vec,
    output logic [SBW-1:0]        o_sb
);

    localparam int NB  = lavm_pkg::NORM_BITS;
    localparam int PW  = $clog2(CW);
    localparam int SB  = NB + 1;
    localparam int RW  = 2 * NB + 2;
    localparam int QB  = AXIS_FRAC_BITS + 1;
    localparam int NW  = NB + AXIS_FRAC_BITS + 1;
    localparam int MTW = 1 + 3 + 3 * NB;
    localparam int LAT = SB + QB + 7;

    logic [LAT-1:0]  r_vld;
    logic [SBW-1:0]  r_sb [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sb[0] <= i_sb;
            for (int i = 1; i < LAT; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    function automatic logic [PW-1:0] f_msb(input logic [CW-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < CW; i++) begin
            if (v[i]) p = PW'(i);
        end
        return p;
    endfunction

    // Magnitudes and signs.
    logic [CW-1:0]        c_mag [3];
    logic [CW-1:0]        r1_w  [3];
    logic [2:0]           r1_neg;
    logic [CW-1:0]        r1_or;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_mag[k] = i_vec[k*CW+CW-1] ? (~i_vec[k*CW +: CW] + 1'b1) : i_vec[k*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r1_w[k]   <= c_mag[k];
                r1_neg[k] <= i_vec[k*CW+CW-1];
            end
            r1_or <= c_mag[0] | c_mag[1] | c_mag[2];
        end
    end

    // The leading one of the OR is the leading one of the largest magnitude.
    logic [CW-1:0]        r2_w [3];
    logic [2:0]           r2_neg;
    logic [PW-1:0]        r2_pos;
    logic                 r2_zero;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_w    <= r1_w;
            r2_neg  <= r1_neg;
            r2_pos  <= f_msb(r1_or);
            r2_zero <= (r1_or == '0);
        end
    end

    logic [CW+NB-1:0]     c_wide [3];
    logic [2:0][NB-1:0]   r3_w;
    logic [2:0]           r3_neg;
    logic                 r3_zero;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r2_pos >= PW'(NB - 1)) begin
                c_wide[k] = {{NB{1'b0}}, r2_w[k]} >> (r2_pos - PW'(NB - 1));
            end else begin
                c_wide[k] = {{NB{1'b0}}, r2_w[k]} << (PW'(NB - 1) - r2_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r3_w[k] <= c_wide[k][NB-1:0];
            end
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
        end
    end

    logic [2*NB-1:0]      r4_sq [3];
    logic [2:0][NB-1:0]   r4_w;
    logic [2:0]           r4_neg;
    logic                 r4_zero;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                r4_sq[k] <= r3_w[k] * r3_w[k];
            end
            r4_w    <= r3_w;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
        end
    end

    // Integer square root, one result bit per stage; stage 0 forms the sum.
    logic [RW-1:0]  r_rem  [SB+1];
    logic [SB-1:0]  r_root [SB+1];
    logic [MTW-1:0] r_qm   [SB+1];

    genvar t;
    generate
        for (t = 0; t <= SB; t++) begin : g_sqrt
            if (t == 0) begin : g_sum
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        r_rem[0]  <= RW'(r4_sq[0]) + RW'(r4_sq[1]) + RW'(r4_sq[2]);
                        r_root[0] <= '0;
                        r_qm[0]   <= {r4_zero, r4_neg, r4_w};
                    end
                end
            end else begin : g_bit
                localparam int B = SB - t;
                logic [RW:0] c_cand;
                logic        c_ge;
                always_comb begin
                    c_cand = ((RW+1)'(r_root[t-1]) << (B + 1)) + ((RW+1)'(1) << (2 * B));
                    c_ge   = ({1'b0, r_rem[t-1]} >= c_cand);
                end
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        r_rem[t]  <= c_ge ? (r_rem[t-1] - c_cand[RW-1:0]) : r_rem[t-1];
                        r_root[t] <= c_ge ? (r_root[t-1] | (SB'(1) << B)) : r_root[t-1];
                        r_qm[t]   <= r_qm[t-1];
                    end
                end
            end
        end
    endgenerate

    // Rounded division of each magnitude by the length, one quotient bit per stage.
    logic [2:0][NB-1:0] c_lw;
    logic [2:0]         c_lneg;
    logic               c_lzero;
    logic [NW-1:0]      r_dr [QB+1][3];
    logic [QB-1:0]      r_dq [QB+1][3];
    logic [SB-1:0]      r_dl [QB+1];
    logic [3:0]         r_dm [QB+1];

    assign {c_lzero, c_lneg, c_lw} = r_qm[SB];

    generate
        for (t = 0; t <= QB; t++) begin : g_div
            if (t == 0) begin : g_num
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        for (int k = 0; k < 3; k++) begin
                            r_dr[0][k] <= (NW'(c_lw[k]) << AXIS_FRAC_BITS)
                                          + NW'(r_root[SB] >> 1);
                            r_dq[0][k] <= '0;
                        end
                        r_dl[0] <= r_root[SB];
                        r_dm[0] <= {c_lzero, c_lneg};
                    end
                end
            end else begin : g_bit
                localparam int J = QB - t;
                logic [NW-1:0] c_trial;
                logic [2:0]    c_ge;
                always_comb begin
                    c_trial = NW'(r_dl[t-1]) << J;
                    for (int k = 0; k < 3; k++) begin
                        c_ge[k] = (r_dr[t-1][k] >= c_trial);
                    end
                end
                always_ff @(posedge i_clk) begin
                    if (i_ce) begin
                        for (int k = 0; k < 3; k++) begin
                            r_dr[t][k] <= c_ge[k] ? (r_dr[t-1][k] - c_trial) : r_dr[t-1][k];
                            r_dq[t][k] <= r_dq[t-1][k] | (c_ge[k] ? (QB'(1) << J) : '0);
                        end
                        r_dl[t] <= r_dl[t-1];
                        r_dm[t] <= r_dm[t-1];
                    end
                end
            end
        end
    endgenerate

    lavm_pkg::t_vec3 r_out;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < 3; k++) begin
                if (r_dm[QB][3]) begin
                    r_out[k] <= '0;
                end else if (r_dm[QB][k]) begin
                    r_out[k] <= -lavm_pkg::WORD_W'(r_dq[QB][k]);
                end else begin
                    r_out[k] <= lavm_pkg::WORD_W'(r_dq[QB][k]);
                end
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_vec   = r_out;
    assign o_sb    = r_sb[LAT-1];

endmodule

>>> rtl/lavm_cross.sv
module lavm_cross #(
    parameter int SBW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  lavm_pkg::t_vec3       i_a,
    input  lavm_pkg::t_vec3       i_b,
    input  logic [SBW-1:0]        i_sb,
    output logic                  o_valid,
    output logic [2:0][63:0]      o_c,
    output logic [SBW-1:0]        o_sb
);

    logic signed [63:0] r_p [6];
    logic [2:0][63:0]   r_c;
    logic [1:0]         r_vld;
    logic [SBW-1:0]     r_sb [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);
            r_c[0] <= r_p[0] - r_p[1];
            r_c[1] <= r_p[2] - r_p[3];
            r_c[2] <= r_p[4] - r_p[5];
            r_sb[0] <= i_sb;
            r_sb[1] <= r_sb[0];
        end
    end

    assign o_valid = r_vld[1];
    assign o_c     = r_c;
    assign o_sb    = r_sb[1];

endmodule

>>> rtl/look_at_view_matrix.sv
// Look-at view matrix builder.
// Input channel (i_s_axis_*): one item holds the eye point, the target point and
// the up vector, nine signed Q16.16 words. Output channel (o_m_axis_*): one item
// holds the rows side, true up and back, each as three Q2.30 axis components
// followed by a saturated Q16.16 offset.
// Every accepted item gives exactly one result item, in order.
// Throughput: one item per cycle while o_s_axis_tready is high. Each of the
// two vector normalizations costs AXIS_FRAC_BITS + 39 stages, set by the
// square root (one bit per stage) and the three divider lanes (one quotient
// bit per stage).
// Reset clears all valid bits; no result is presented until new items arrive.
// When the receiver stalls, the output register holds its item and one more
// result lands in a skid register; o_s_axis_tready then drops and the whole
// pipeline freezes until the skid register is drained. Nothing is lost.
module look_at_view_matrix #(
    parameter int AXIS_FRAC_BITS = lavm_pkg::AXIS_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [lavm_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // side_x, side_y, side_z, side_offset, upward_x, upward_y, upward_z,
    // upward_offset, back_x, back_y, back_z, back_offset
    output logic [lavm_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    localparam int                 WW      = lavm_pkg::WORD_W;
    localparam logic signed [63:0] LIM     = 64'sd1 <<< AXIS_FRAC_BITS;
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [63:0] f_round(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    logic ce;
    logic r_skid_vld;

    assign ce              = !r_skid_vld;
    assign o_s_axis_tready = ce;

    // Input stage: direction from eye to target, one bit wider.
    lavm_pkg::t_vec3  c_eye, c_tgt, c_up;
    logic [2:0][32:0] c_d;
    logic             r_in_vld;
    logic [2:0][32:0] r_d;
    lavm_pkg::t_vec3  r_eye, r_up;

    assign c_eye = i_s_axis_tdata[3*WW-1:0];
    assign c_tgt = i_s_axis_tdata[6*WW-1:3*WW];
    assign c_up  = i_s_axis_tdata[9*WW-1:6*WW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_d[k] = {c_tgt[k][WW-1], c_tgt[k]} - {c_eye[k][WW-1], c_eye[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (ce) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_d   <= c_d;
            r_eye <= c_eye;
            r_up  <= c_up;
        end
    end

    // Forward axis.
    logic             n1_vld;
    lavm_pkg::t_vec3  n1_fwd;
    logic [6*WW-1:0]  n1_sb;

    lavm_norm #(
        .CW             (33),
        .SBW            (6 * WW),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_in_vld),
        .i_vec   (r_d),
        .i_sb    ({r_up, r_eye}),
        .o_valid (n1_vld),
        .o_vec   (n1_fwd),
        .o_sb    (n1_sb)
    );

    logic             x1_vld;
    logic [2:0][63:0] x1_c;
    logic [6*WW-1:0]  x1_sb;

    lavm_cross #(
        .SBW (6 * WW)
    ) u_cross_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (n1_vld),
        .i_a     (n1_fwd),
        .i_b     (n1_sb[6*WW-1:3*WW]),
        .i_sb    ({n1_fwd, n1_sb[3*WW-1:0]}),
        .o_valid (x1_vld),
        .o_c     (x1_c),
        .o_sb    (x1_sb)
    );

    // Side axis.
    logic             n2_vld;
    lavm_pkg::t_vec3  n2_side;
    logic [6*WW-1:0]  n2_sb;

    lavm_norm #(
        .CW             (64),
        .SBW            (6 * WW),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (x1_vld),
        .i_vec   (x1_c),
        .i_sb    (x1_sb),
        .o_valid (n2_vld),
        .o_vec   (n2_side),
        .o_sb    (n2_sb)
    );

    logic             x2_vld;
    logic [2:0][63:0] x2_c;
    logic [9*WW-1:0]  x2_sb;

    lavm_cross #(
        .SBW (9 * WW)
    ) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (n2_vld),
        .i_a     (n2_side),
        .i_b     (n2_sb[6*WW-1:3*WW]),
        .i_sb    ({n2_side, n2_sb}),
        .o_valid (x2_vld),
        .o_c     (x2_c),
        .o_sb    (x2_sb)
    );

    // Rows: side, true up (rounded and clamped), back.
    lavm_pkg::t_vec3    c_fwd;
    lavm_pkg::t_vec3    c_tup;
    logic signed [63:0] c_rt [3];
    logic               r_u_vld;
    lavm_pkg::t_vec3    r_u_row [3];
    lavm_pkg::t_vec3    r_u_eye;

    assign c_fwd = x2_sb[6*WW-1:3*WW];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_rt[k] = f_round($signed(x2_c[k]));
            if (c_rt[k] > LIM) begin
                c_tup[k] = WW'(LIM);
            end else if (c_rt[k] < -LIM) begin
                c_tup[k] = WW'(-LIM);
            end else begin
                c_tup[k] = WW'(c_rt[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_u_row[0] <= x2_sb[9*WW-1:6*WW];
            r_u_row[1] <= c_tup;
            for (int k = 0; k < 3; k++) begin
                r_u_row[2][k] <= -c_fwd[k];
            end
            r_u_eye <= x2_sb[3*WW-1:0];
        end
    end

    // Offsets: products, sums, then rounding and saturation.
    logic               r_o1_vld, r_o2_vld, r_res_vld;
    logic signed [63:0] r_o1_p   [3][3];
    lavm_pkg::t_vec3    r_o1_row [3];
    logic signed [63:0] r_o2_sum [3];
    lavm_pkg::t_vec3    r_o2_row [3];
    logic signed [63:0] c_off    [3];
    logic [lavm_pkg::OUT_W-1:0] c_res;
    logic [lavm_pkg::OUT_W-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_vld   <= 1'b0;
            r_o1_vld  <= 1'b0;
            r_o2_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else if (ce) begin
            r_u_vld   <= x2_vld;
            r_o1_vld  <= r_u_vld;
            r_o2_vld  <= r_o1_vld;
            r_res_vld <= r_o2_vld;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            c_off[r] = -f_round(r_o2_sum[r]);
            if (c_off[r] > SAT_MAX) begin
                c_off[r] = SAT_MAX;
            end else if (c_off[r] < SAT_MIN) begin
                c_off[r] = SAT_MIN;
            end
            for (int k = 0; k < 3; k++) begin
                c_res[r*4*WW + k*WW +: WW] = r_o2_row[r][k];
            end
            c_res[r*4*WW + 3*WW +: WW] = WW'(c_off[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_o1_p[r][k] <= $signed(r_u_row[r][k]) * $signed(r_u_eye[k]);
                end
                r_o2_sum[r] <= r_o1_p[r][0] + r_o1_p[r][1] + r_o1_p[r][2];
            end
            r_o1_row <= r_u_row;
            r_o2_row <= r_o1_row;
            r_res    <= c_res;
        end
    end

    // Output register with one skid entry behind it.
    logic                       c_push;
    logic                       r_out_vld;
    logic [lavm_pkg::OUT_W-1:0] r_out;
    logic [lavm_pkg::OUT_W-1:0] r_skid;

    assign c_push = ce && r_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            priority if (r_skid_vld) begin
                if (i_m_axis_tready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (c_push) begin
                if (!r_out_vld || i_m_axis_tready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (c_push) begin
            if (!r_out_vld || i_m_axis_tready) begin
                r_out <= r_res;
            end else begin
                r_skid <= r_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

>>> rtl/lavm_checker.sv
module lavm_checker #(
    parameter int AXIS_FRAC_BITS = lavm_pkg::AXIS_FRAC_BITS
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [lavm_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    localparam logic signed [31:0] LIM = 32'sd1 <<< AXIS_FRAC_BITS;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    // The input side only closes after the receiver has held off an item.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready dropped without an output stall");

    a_back_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[287:256]) <= LIM) && ($signed(o_m_axis_tdata[287:256]) >= -LIM)
            && ($signed(o_m_axis_tdata[319:288]) <= LIM)
            && ($signed(o_m_axis_tdata[319:288]) >= -LIM)
            && ($signed(o_m_axis_tdata[351:320]) <= LIM)
            && ($signed(o_m_axis_tdata[351:320]) >= -LIM))
        else $error("back axis component out of unit range");

endmodule

bind look_at_view_matrix lavm_checker #(
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
) u_lavm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY = 2 * lavm_pkg::AXIS_FRAC_BITS + 88;
    localparam int AFB = lavm_pkg::AXIS_FRAC_BITS;
    localparam longint AXIS_ONE = longint'(1) << AFB;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    logic [lavm_pkg::IN_W-1:0]   i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    // side_x, side_y, side_z, side_offset, upward_x, upward_y, upward_z,
    // upward_offset, back_x, back_y, back_z, back_offset
    logic [lavm_pkg::OUT_W-1:0]  o_m_axis_tdata;

    logic [lavm_pkg::OUT_W-1:0]  view_rows_q[$];
    int                mismatch_cnt = 0;
    int                hold_cycles = 0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;

    look_at_view_matrix dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint round_axis(longint v);
        longint unsigned m;
        m = (mag64(v) + (longint'(1) << (AFB - 1))) >> AFB;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(input longint v[3], output longint o[3]);
        longint unsigned w[3], m, s, len, q;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            w[i] = mag64(v[i]);
            if (w[i] > m) m = w[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (m >= (longint'(1) << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) w[i] = w[i] >> 1;
        end
        while (m < (longint'(1) << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) w[i] = w[i] << 1;
        end
        for (int i = 0; i < 3; i++) s = s + w[i] * w[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((w[i] << AFB) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_vec(input longint a[3], input longint b[3],
                                      output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [lavm_pkg::OUT_W-1:0] predict_view(
        logic [lavm_pkg::IN_W-1:0] cam);
        longint eye[3], up[3], dir[3], fwd[3], c[3], rows[3][3];
        longint t, sum;
        logic [lavm_pkg::OUT_W-1:0] res;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(cam[32*i +: 32]));
            dir[i] = longint'($signed(cam[32*(3+i) +: 32])) - eye[i];
            up[i]  = longint'($signed(cam[32*(6+i) +: 32]));
        end
        unit_vec(dir, fwd);
        cross_vec(fwd, up, c);
        unit_vec(c, rows[0]);
        cross_vec(rows[0], fwd, c);
        for (int i = 0; i < 3; i++) begin
            t = round_axis(c[i]);
            if (t > AXIS_ONE) t = AXIS_ONE;
            if (t < -AXIS_ONE) t = -AXIS_ONE;
            rows[1][i] = t;
            rows[2][i] = -fwd[i];
        end
        for (int r = 0; r < 3; r++) begin
            sum = rows[r][0] * eye[0] + rows[r][1] * eye[1] + rows[r][2] * eye[2];
            t = -round_axis(sum);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            for (int i = 0; i < 3; i++) res[32*(4*r+i) +: 32] = rows[r][i][31:0];
            res[32*(4*r+3) +: 32] = t[31:0];
        end
        return res;
    endfunction

    // Receiver: random stalls, now and then a longer one, and one long hold-off
    // when it is requested.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_req && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles <= 599;
            hold_done <= 1'b1;
        end else if ($urandom_range(0, 99) == 0) begin
            i_m_axis_tready <= 1'b0;
            hold_cycles <= $urandom_range(10, 40);
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        logic [lavm_pkg::OUT_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (view_rows_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("Unexpected result item %h", o_m_axis_tdata);
            end else begin
                want = view_rows_q.pop_front();
                for (int f = 0; f < 12; f++) begin
                    if (o_m_axis_tdata[32*f +: 32] !== want[32*f +: 32]) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("Field %0d: expected %h, got %h", f,
                                     want[32*f +: 32], o_m_axis_tdata[32*f +: 32]);
                    end
                end
            end
        end
    end

    task automatic send_camera(logic [lavm_pkg::IN_W-1:0] cam, bit with_gaps = 1);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= cam;
        do @(posedge i_clk); while (!o_s_axis_tready);
        view_rows_q.push_back(predict_view(cam));
        gap = 0;
        if (with_gaps) begin
            gap = $urandom_range(0, 9);
            gap = gap < 5 ? 0 : (gap < 9 ? $urandom_range(1, 3) : $urandom_range(10, 60));
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [lavm_pkg::IN_W-1:0] pack_camera(int ex, int ey, int ez,
                                                             int tx, int ty, int tz,
                                                             int ux, int uy, int uz);
        return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
            default: return $signed($urandom_range(0, 32)) - 16;
        endcase
    endfunction

    function automatic logic [lavm_pkg::IN_W-1:0] rand_camera();
        int ex, ey, ez, tx, ty, tz, ux, uy, uz, k;
        ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
        tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
        ux = rand_coord(); uy = rand_coord(); uz = rand_coord();
        k = $urandom_range(0, 19);
        if (k == 0) begin
            tx = ex; ty = ey; tz = ez;
        end else if (k == 1) begin
            ux = 0; uy = 0; uz = 0;
        end else if (k == 2) begin
            // Up along the view direction, so the side axis collapses.
            ux = tx - ex; uy = ty - ey; uz = tz - ez;
        end
        return pack_camera(ex, ey, ez, tx, ty, tz, ux, uy, uz);
    endfunction

    task automatic test_directed();
        int mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        send_camera(pack_camera(0, 0, 327680, 0, 0, 0, 0, 65536, 0));
        send_camera(pack_camera(65536, 131072, 196608, 65536, 131072, 196608, 0, 65536, 0));
        send_camera(pack_camera(0, 0, 0, 65536, 65536, 0, 0, 0, 0));
        send_camera(pack_camera(0, 0, 0, 0, 65536, 0, 0, 131072, 0));
        send_camera(pack_camera(0, 0, 0, 0, 0, -65536, 0, -65536, 0));
        send_camera(pack_camera(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_camera(pack_camera(mn, mn, mn, mx, mx, mx, mn, mx, mn));
        send_camera(pack_camera(mx, mn, mx, mn, mx, mn, mx, mx, mx));
        send_camera(pack_camera(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_camera(pack_camera(mx, 0, mn, 0, 0, 0, 1, 0, 0));
        send_camera(pack_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_camera(pack_camera(-1, -1, -1, 0, 0, 0, 0, 0, 1));
        send_camera(pack_camera(mx, mx, 0, mn, mn, 0, 0, 0, mx));
        send_camera(pack_camera(0, 0, 0, 3, -5, 7, -1, 2, -3));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_camera(rand_camera());
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        for (int n = 0; n < 300; n++) send_camera(rand_camera(), 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        test_backpressure();
        test_random(840);
        i_s_axis_tvalid <= 1'b0;
        while (view_rows_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 50) @(posedge i_clk);
        if (mismatch_cnt == 0 && view_rows_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> filelist.f
rtl/lavm_pkg.sv
rtl/lavm_norm.sv
rtl/lavm_cross.sv
rtl/look_at_view_matrix.sv
rtl/lavm_checker.sv
verif/tb.sv
